// ===== sv/sfhc_pkg.sv =====
package sfhc_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
  localparam logic [63:0] GOLDEN    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] ONE64     = 64'd1;

  // control bits carried along with each word
  typedef struct packed {
    logic first;
    logic seed;
    logic close;
    logic msg_end;
  } seg_ctl_t;

  // multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifted copies
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [63:0] hash_fold(input logic [63:0] h, input logic [63:0] s);
    return h ^ (s + GOLDEN + (h << 6) + (h >> 2));
  endfunction

endpackage

// ===== sv/sfhc_seg.sv =====
module sfhc_seg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [7:0]        data_byte,
  input  logic              byte_present,
  input  sfhc_pkg::seg_ctl_t ctl,
  output logic [63:0]       seg_out,
  output sfhc_pkg::seg_ctl_t ctl_out
);
  import sfhc_pkg::*;

  logic [63:0] seg;
  logic [63:0] seg_base;
  logic [63:0] seg_mixed;
  logic [63:0] seg_new;

  always_comb begin
    seg_base  = ctl.first ? FNV_BASIS : seg;
    seg_mixed = seg_base ^ {56'd0, data_byte};
    seg_new   = byte_present ? fnv_mul(seg_mixed) : seg_base;
  end

  // running segment state; closing a segment restarts from the basis
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= FNV_BASIS;
    end else if (load) begin
      seg <= ctl.close ? FNV_BASIS : seg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg_out <= seg_new;
      ctl_out <= ctl;
    end
  end

endmodule

// ===== sv/segmented_fnv1a_hash_combine.sv =====
// A word accepted goes into the input register, then into the segment hash register,
// and a digest then goes into the output register.
// Throughput: one word per cycle unless stalled; FNV step and fold are each one register stage.
// While a digest waits, words keep flowing until the next message-ending word reaches the fold.
// Reset (rst, synchronous): running hash 0, segment hash at the offset basis, pipeline empty.
module segmented_fnv1a_hash_combine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        first_of_message,
  input  logic        seed_flag,
  input  logic        segment_end,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest
);
  import sfhc_pkg::*;

  // input register
  logic       v1;
  logic [7:0] byte1;
  logic       present1;
  seg_ctl_t   ctl1;

  // segment stage
  logic        v2;
  logic [63:0] seg2;
  seg_ctl_t    ctl2;

  logic [63:0] running;
  logic [63:0] h_base;
  logic [63:0] h_new;
  logic        out_free;
  logic        fold_fire;
  logic        adv2;
  logic        move1;
  logic        accept;

  always_comb begin
    out_free  = !out_valid || out_ready;
    fold_fire = v2 && (!ctl2.msg_end || out_free);
    adv2      = !v2 || fold_fire;
    move1     = v1 && adv2;
    in_ready  = !v1 || adv2;
    accept    = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (move1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte1         <= data_byte;
      present1      <= byte_present;
      ctl1.first    <= first_of_message;
      ctl1.seed     <= seed_flag;
      ctl1.close    <= segment_end | message_end;
      ctl1.msg_end  <= message_end;
    end
  end

  sfhc_seg u_seg (
    .clk          (clk),
    .rst          (rst),
    .load         (move1),
    .data_byte    (byte1),
    .byte_present (present1),
    .ctl          (ctl1),
    .seg_out      (seg2),
    .ctl_out      (ctl2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= move1;
    end
  end

  always_comb begin
    h_base = ctl2.first ? {63'd0, ctl2.seed} : running;
    h_new  = ctl2.close ? hash_fold(h_base, seg2) : h_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 64'd0;
    end else if (fold_fire) begin
      running <= ctl2.msg_end ? 64'd0 : h_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fold_fire && ctl2.msg_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a zero hash goes out as one
  always_ff @(posedge clk) begin
    if (fold_fire && ctl2.msg_end) begin
      digest <= (h_new == 64'd0) ? ONE64 : h_new;
    end
  end

endmodule

// ===== tb/segmented_fnv1a_hash_combine_tb.sv =====
`timescale 1ns / 100ps

module segmented_fnv1a_hash_combine_tb;
  import sfhc_pkg::*;

  // Predicts message digests from accepted words and checks them in order.
  class digest_scoreboard;
    logic [63:0] run_h;
    logic [63:0] seg_h;
    logic [63:0] digest_q[$];
    int errors;

    function new();
      run_h = 64'd0;
      seg_h = FNV_BASIS;
      errors = 0;
    endfunction

    function void note_word(logic [7:0] b, logic present, logic first, logic seed,
                            logic seg_end, logic msg_end);
      if (first) begin
        run_h = {63'd0, seed};
        seg_h = FNV_BASIS;
      end
      if (present) begin
        seg_h = (seg_h ^ {56'd0, b}) * FNV_PRIME;
      end
      if (seg_end || msg_end) begin
        run_h = run_h ^ (seg_h + GOLDEN + (run_h << 6) + (run_h >> 2));
        seg_h = FNV_BASIS;
      end
      if (msg_end) begin
        digest_q.insert(digest_q.size(), (run_h == 64'd0) ? ONE64 : run_h);
        run_h = 64'd0;
      end
    endfunction

    function void check_digest(logic [63:0] got);
      logic [63:0] want;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest %h", got);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("digest mismatch: expected %h got %h", want, got);
        end
      end
    endfunction

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        byte_present = 1'b0;
  logic        first_of_message = 1'b0;
  logic        seed_flag = 1'b0;
  logic        segment_end = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest;

  digest_scoreboard sb;
  int words_sent = 0;
  int burst_left = 0;

  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  segmented_fnv1a_hash_combine dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .byte_present(byte_present),
    .first_of_message(first_of_message),
    .seed_flag(seed_flag),
    .segment_end(segment_end),
    .message_end(message_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .digest(digest)
  );

  always #5 clk = ~clk;

  // receiver: stall pattern switches between a few modes every so often
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(32, 256);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
      RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 2);
      default:   out_ready <= (rx_tick % 5 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_digest(digest);
  end

  // after each accepted word: keep going within a burst, else drop valid for a gap
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic present, input logic first,
                           input logic seed, input logic seg_end, input logic msg_end);
    in_valid <= 1'b1;
    data_byte <= b;
    byte_present <= present;
    first_of_message <= first;
    seed_flag <= seed;
    segment_end <= seg_end;
    message_end <= msg_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(b, present, first, seed, seg_end, msg_end);
    if (present || first || seg_end || msg_end) words_sent++;
    pace();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // well-formed message with random content; empty segments use a marker word
  task automatic send_message(input bit with_first, input int nseg, input int maxlen);
    bit is_first;
    bit seed;
    bit last_seg;
    bit closes;
    int seg_len;
    is_first = with_first;
    seed = 1'($urandom_range(0, 1));
    for (int s = 0; s < nseg; s++) begin
      last_seg = (s == nseg - 1);
      seg_len = $urandom_range(0, maxlen);
      if (seg_len == 0) begin
        send_word(8'($urandom), 1'b0, is_first, is_first ? seed : 1'($urandom_range(0, 1)),
                  last_seg ? 1'($urandom_range(0, 1)) : 1'b1, last_seg);
        is_first = 1'b0;
      end else begin
        for (int k = 0; k < seg_len; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_word(8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
          closes = (k == seg_len - 1);
          send_word(8'($urandom), 1'b1, is_first,
                    is_first ? seed : 1'($urandom_range(0, 1)),
                    closes ? (last_seg ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0,
                    closes && last_seg);
          is_first = 1'b0;
        end
      end
    end
  endtask

  initial begin
    int waited;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single empty-segment messages, both seeds
    send_word(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    // single-byte messages at the byte extremes
    send_word(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    // several segments with an idle word and an empty segment inside
    send_word(8'ha5, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_word(8'h5a, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_word(8'h3c, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_word(8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    // restart mid-message: by an idle word, then by a word carrying a byte
    send_word(8'h11, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    send_word(8'h22, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_word(8'h33, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    send_word(8'h44, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    send_word(8'h55, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
    // message without a first word runs from seed 0
    send_word(8'h7f, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    send_word(8'hfe, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    // a zero digest needs an FNV-1a preimage; only the predictor covers it
    drain();

    while (words_sent < 2000) begin
      if (words_sent > 1000 && words_sent < 1020) drain();
      if ($urandom_range(0, 99) < 85) begin
        send_message($urandom_range(0, 9) != 0, $urandom_range(1, 5), $urandom_range(0, 8));
      end else begin
        send_word(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                  1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 7) == 0);
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[segmented_fnv1a_hash_combine] OK");
    end else begin
      $display("[segmented_fnv1a_hash_combine] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[segmented_fnv1a_hash_combine] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/sfhc_pkg.sv
sv/sfhc_seg.sv
sv/segmented_fnv1a_hash_combine.sv
tb/segmented_fnv1a_hash_combine_tb.sv
